/* rtl/lcs_pkg.sv */
// Package for the load completion scoreboard.
// Holds widths, request and phase codes and the request struct.
// No dependencies.
package lcs_pkg;

  localparam int MaxLoadsDef = 16;
  localparam int TokenBits   = 32;
  localparam int GenW        = 64;
  localparam int ModeW       = 3;
  localparam int OutcomeW    = 2;
  localparam int StateW      = 3;
  localparam int ApbAddrW    = 1;
  localparam int ApbDataW    = 64;

  localparam logic [ApbAddrW-1:0] RegBatchGen = 1'b0;

  localparam logic [ModeW-1:0] MODE_LOAD     = 3'd0;
  localparam logic [ModeW-1:0] MODE_SEAL     = 3'd1;
  localparam logic [ModeW-1:0] MODE_COMPLETE = 3'd2;
  localparam logic [ModeW-1:0] MODE_CANCEL   = 3'd3;
  localparam logic [ModeW-1:0] MODE_TIMEOUT  = 3'd4;
  localparam logic [ModeW-1:0] MODE_CLEAR    = 3'd5;

  localparam logic [OutcomeW-1:0] OUTCOME_READY  = 2'd0;
  localparam logic [OutcomeW-1:0] OUTCOME_FAILED = 2'd1;

  localparam logic [StateW-1:0] PH_BUILDING  = 3'd0;
  localparam logic [StateW-1:0] PH_PENDING   = 3'd1;
  localparam logic [StateW-1:0] PH_READY     = 3'd2;
  localparam logic [StateW-1:0] PH_FAILED    = 3'd3;
  localparam logic [StateW-1:0] PH_CANCELLED = 3'd4;
  localparam logic [StateW-1:0] PH_TIMEOUT   = 3'd5;
  localparam logic [StateW-1:0] PH_INVALID   = 3'd6;

  typedef struct packed {
    logic [ModeW-1:0]     mode;
    logic [TokenBits-1:0] token;
    logic [GenW-1:0]      request_generation;
    logic [OutcomeW-1:0]  outcome;
  } item_t;

endpackage

/* rtl/lcs_if.sv */
// Request and result channel interfaces for the load completion scoreboard.
// Depends on lcs_pkg.
interface lcs_req_if;
  import lcs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ModeW-1:0]     mode;
  logic [TokenBits-1:0] token;
  logic [GenW-1:0]      request_generation;
  logic [OutcomeW-1:0]  outcome;

  modport source (output valid, mode, token, request_generation, outcome, input ready);
  modport sink (input valid, mode, token, request_generation, outcome, output ready);
endinterface

interface lcs_rsp_if #(
  parameter int CntW = 5,
  parameter int IdxW = 4
);
  import lcs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [StateW-1:0]    batch_state;
  logic [CntW-1:0]      remaining_count;
  logic                 failed_valid;
  logic [IdxW-1:0]      failed_slot;
  logic [TokenBits-1:0] failed_token;

  modport source (output valid, accepted, batch_state, remaining_count, failed_valid,
                  failed_slot, failed_token, input ready);
  modport sink (input valid, accepted, batch_state, remaining_count, failed_valid,
                failed_slot, failed_token, output ready);
endinterface

/* rtl/lcs_apb_regs.sv */
// APB configuration register for the load completion scoreboard.
// Holds batch_generation; depends on lcs_pkg.
module lcs_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lcs_pkg::ApbAddrW-1:0]   paddr,
  input  logic [lcs_pkg::ApbDataW-1:0]   pwdata,
  output logic [lcs_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,
  output logic [lcs_pkg::GenW-1:0]       batch_gen_o
);
  import lcs_pkg::*;

  logic [GenW-1:0] batch_gen_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == RegBatchGen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_gen_q <= '0;
    end else if (wr_en) begin
      batch_gen_q <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == RegBatchGen) begin
      prdata = batch_gen_q;
    end
  end

  assign batch_gen_o = batch_gen_q;

endmodule

/* rtl/lcs_in_reg.sv */
// Input register stage of the load completion scoreboard.
// Captures one request per cycle while the core takes items; depends on lcs_pkg and lcs_req_if.
module lcs_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  lcs_req_if.sink        req,
  output logic           item_valid_o,
  output lcs_pkg::item_t item_o,
  input  logic           item_ready_i
);
  import lcs_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  take;

  assign req.ready = !valid_q || item_ready_i;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (item_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.mode               <= req.mode;
      item_q.token              <= req.token;
      item_q.request_generation <= req.request_generation;
      item_q.outcome            <= req.outcome;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* rtl/lcs_core.sv */
// Batch state, token table and result register of the load completion scoreboard.
// Depends on lcs_pkg and lcs_rsp_if.
module lcs_core #(
  parameter int MaxLoads = lcs_pkg::MaxLoadsDef,
  parameter int CntW     = $clog2(MaxLoads + 1),
  parameter int IdxW     = (MaxLoads > 1) ? $clog2(MaxLoads) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  input  lcs_pkg::item_t           item_i,
  output logic                     item_ready_o,
  input  logic [lcs_pkg::GenW-1:0] batch_gen_i,
  lcs_rsp_if.source                rsp
);
  import lcs_pkg::*;

  logic [TokenBits-1:0] table_q [MaxLoads];

  logic [StateW-1:0]    phase_q, phase_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      left_q, left_d, left_dec;
  logic [MaxLoads-1:0]  done_q, done_d;
  logic                 bad_q, bad_d;
  logic                 fv_q, fv_d;
  logic [IdxW-1:0]      fslot_q, fslot_d;
  logic [TokenBits-1:0] ftok_q, ftok_d;

  logic [MaxLoads-1:0]  hit_vec;
  logic [MaxLoads-1:0]  open_vec;
  logic [IdxW-1:0]      sel_idx;
  logic                 proc;
  logic                 acc;
  logic                 wr_en;

  logic                 out_v_q;
  logic                 acc_q;
  logic [StateW-1:0]    state_q;
  logic [CntW-1:0]      rem_q;
  logic                 ofv_q;
  logic [IdxW-1:0]      oslot_q;
  logic [TokenBits-1:0] otok_q;

  assign item_ready_o = !out_v_q || rsp.ready;
  assign proc         = item_valid_i && item_ready_o;

  always_comb begin
    for (int i = 0; i < MaxLoads; i++) begin
      hit_vec[i] = (CntW'(i) < cnt_q) && (table_q[i] == item_i.token);
    end
    open_vec = hit_vec & ~done_q;
    sel_idx  = '0;
    for (int i = MaxLoads - 1; i >= 0; i--) begin
      if (open_vec[i]) begin
        sel_idx = IdxW'(i);
      end
    end
  end

  assign left_dec = (left_q != '0) ? left_q - CntW'(1) : left_q;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    done_d  = done_q;
    bad_d   = bad_q;
    fv_d    = fv_q;
    fslot_d = fslot_q;
    ftok_d  = ftok_q;
    acc     = 1'b0;
    wr_en   = 1'b0;
    if (proc) begin
      unique case (item_i.mode)
        MODE_LOAD: begin
          if (phase_q == PH_BUILDING && !bad_q) begin
            if (item_i.token == '0 || cnt_q >= CntW'(MaxLoads) || (|hit_vec)) begin
              bad_d = 1'b1;
            end else begin
              wr_en = 1'b1;
              cnt_d = cnt_q + CntW'(1);
              acc   = 1'b1;
            end
          end
        end
        MODE_SEAL: begin
          if (phase_q == PH_BUILDING) begin
            if (bad_q || batch_gen_i == '0) begin
              phase_d = PH_INVALID;
            end else begin
              done_d  = '0;
              left_d  = cnt_q;
              phase_d = (cnt_q == '0) ? PH_READY : PH_PENDING;
              acc     = 1'b1;
            end
          end
        end
        MODE_COMPLETE: begin
          if (phase_q == PH_PENDING && item_i.request_generation == batch_gen_i &&
              item_i.token != '0 && (|open_vec)) begin
            if (item_i.outcome == OUTCOME_READY) begin
              done_d = done_q | (MaxLoads'(1) << sel_idx);
              left_d = left_dec;
              if (left_dec == '0) begin
                phase_d = PH_READY;
              end
              acc = 1'b1;
            end else if (item_i.outcome == OUTCOME_FAILED) begin
              fv_d    = 1'b1;
              fslot_d = sel_idx;
              ftok_d  = item_i.token;
              phase_d = PH_FAILED;
              acc     = 1'b1;
            end
          end
        end
        MODE_CANCEL: begin
          if (phase_q == PH_PENDING) begin
            phase_d = PH_CANCELLED;
            acc     = 1'b1;
          end
        end
        MODE_TIMEOUT: begin
          if (phase_q == PH_PENDING) begin
            phase_d = PH_TIMEOUT;
            acc     = 1'b1;
          end
        end
        MODE_CLEAR: begin
          phase_d = PH_BUILDING;
          cnt_d   = '0;
          left_d  = '0;
          done_d  = '0;
          bad_d   = 1'b0;
          fv_d    = 1'b0;
          acc     = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BUILDING;
      cnt_q   <= '0;
      left_q  <= '0;
      done_q  <= '0;
      bad_q   <= 1'b0;
      fv_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      done_q  <= done_d;
      bad_q   <= bad_d;
      fv_q    <= fv_d;
      if (proc) begin
        out_v_q <= 1'b1;
      end else if (rsp.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fslot_q <= fslot_d;
    ftok_q  <= ftok_d;
    if (wr_en) begin
      table_q[cnt_q[IdxW-1:0]] <= item_i.token;
    end
    if (proc) begin
      acc_q   <= acc;
      state_q <= phase_d;
      rem_q   <= left_d;
      ofv_q   <= fv_d;
      oslot_q <= fv_d ? fslot_d : '0;
      otok_q  <= fv_d ? ftok_d : '0;
    end
  end

  assign rsp.valid           = out_v_q;
  assign rsp.accepted        = acc_q;
  assign rsp.batch_state     = state_q;
  assign rsp.remaining_count = rem_q;
  assign rsp.failed_valid    = ofv_q;
  assign rsp.failed_slot     = oslot_q;
  assign rsp.failed_token    = otok_q;

  a_left_within_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= cnt_q)
    else $error("left count exceeds entry count");

  a_building_no_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BUILDING) |-> (left_q == '0 && done_q == '0))
    else $error("building batch has outstanding loads");

  a_fail_latch_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fv_q == (phase_q == PH_FAILED))
    else $error("failure latch out of step with phase");

  a_pending_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PENDING) |-> ($countones(done_q) + int'(left_q) == int'(cnt_q)
                                 && left_q != '0))
    else $error("done bits and left count disagree");

  a_result_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> (out_v_q && state_q == phase_q))
    else $error("result register missed a request");

endmodule

/* rtl/load_completion_scoreboard.sv */
// Load completion scoreboard top level: tracks one batch of tagged loads.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle while rsp.ready; token match is a single parallel compare.
// Reset clears batch state, failure latch and batch_generation; the table needs no clearing.
// Depends on lcs_pkg, lcs_if, lcs_apb_regs, lcs_in_reg and lcs_core.
module load_completion_scoreboard #(
  parameter int MaxLoads = lcs_pkg::MaxLoadsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lcs_req_if.sink                      req,
  lcs_rsp_if.source                    rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcs_pkg::ApbAddrW-1:0] paddr,
  input  logic [lcs_pkg::ApbDataW-1:0] pwdata,
  output logic [lcs_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);
  import lcs_pkg::*;

  logic            item_valid;
  logic            item_ready;
  item_t           item;
  logic [GenW-1:0] batch_gen;

  lcs_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .batch_gen_o (batch_gen)
  );

  lcs_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  lcs_core #(
    .MaxLoads (MaxLoads)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .batch_gen_i  (batch_gen),
    .rsp          (rsp)
  );

endmodule

/* test/tb_load_completion_scoreboard.sv */
// Self-checking testbench for load_completion_scoreboard: builds, seals and completes
// random batches of tagged loads under backpressure and checks every status result.
// Depends on lcs_pkg, lcs_if and the block's RTL.
module tb_load_completion_scoreboard;
  import lcs_pkg::*;

  localparam int ClkPeriod     = 4;
  localparam int ResetCycles   = 11;
  localparam int TimeoutCycles = 600000;
  localparam int Phases        = 10;
  localparam int PhaseWork     = 160;
  localparam int LongHold      = 120;

  localparam logic [ModeW-1:0]    MODE_RSVD_LO  = 3'd6;
  localparam logic [ModeW-1:0]    MODE_RSVD_HI  = 3'd7;
  localparam logic [OutcomeW-1:0] OUTCOME_OTHER = 2'd2;
  localparam logic [OutcomeW-1:0] OUTCOME_SPARE = 2'd3;

  typedef struct packed {
    logic                 accepted;
    logic [StateW-1:0]    batch_state;
    logic [4:0]           remaining_count;
    logic                 failed_valid;
    logic [3:0]           failed_slot;
    logic [TokenBits-1:0] failed_token;
  } status_t;

  class batch_tracker;
    logic [GenW-1:0]        gen = '0;
    logic [TokenBits-1:0]   slot_tokens [MaxLoadsDef];
    int                     loaded = 0;
    logic [MaxLoadsDef-1:0] done_mask = '0;
    int                     left = 0;
    logic [StateW-1:0]      phase = PH_BUILDING;
    bit                     bad = 1'b0;
    int                     fail_idx = 0;
    bit                     fail_latched = 1'b0;
    status_t                expected_status [$];
    int                     checked = 0;
    int                     errors = 0;

    function bit absorb_request(item_t it);
      bit      acc;
      bit      hit;
      int      slot;
      status_t want;
      acc  = 1'b0;
      hit  = 1'b0;
      slot = -1;
      case (it.mode) inside
        MODE_LOAD: begin
          if (phase == PH_BUILDING && !bad) begin
            for (int i = 0; i < loaded; i++) begin
              if (slot_tokens[i] == it.token) hit = 1'b1;
            end
            if (it.token == '0 || loaded >= MaxLoadsDef || hit) begin
              bad = 1'b1;
            end else begin
              slot_tokens[loaded] = it.token;
              loaded++;
              acc = 1'b1;
            end
          end
        end
        MODE_SEAL: begin
          if (phase == PH_BUILDING) begin
            if (bad || gen == '0) begin
              phase = PH_INVALID;
            end else begin
              done_mask = '0;
              left      = loaded;
              phase     = (loaded == 0) ? PH_READY : PH_PENDING;
              acc       = 1'b1;
            end
          end
        end
        MODE_COMPLETE: begin
          if (phase == PH_PENDING && it.request_generation == gen && it.token != '0) begin
            for (int i = 0; i < loaded; i++) begin
              if (slot < 0 && slot_tokens[i] == it.token && !done_mask[i]) slot = i;
            end
            if (slot >= 0 && it.outcome == OUTCOME_READY) begin
              done_mask[slot] = 1'b1;
              if (left > 0) left--;
              if (left == 0) phase = PH_READY;
              acc = 1'b1;
            end else if (slot >= 0 && it.outcome == OUTCOME_FAILED) begin
              fail_idx     = slot;
              fail_latched = 1'b1;
              phase        = PH_FAILED;
              acc          = 1'b1;
            end
          end
        end
        MODE_CANCEL, MODE_TIMEOUT: begin
          if (phase == PH_PENDING) begin
            phase = (it.mode == MODE_CANCEL) ? PH_CANCELLED : PH_TIMEOUT;
            acc   = 1'b1;
          end
        end
        MODE_CLEAR: begin
          loaded       = 0;
          done_mask    = '0;
          left         = 0;
          phase        = PH_BUILDING;
          bad          = 1'b0;
          fail_idx     = 0;
          fail_latched = 1'b0;
          acc          = 1'b1;
        end
        default: begin
        end
      endcase
      want.accepted        = acc;
      want.batch_state     = phase;
      want.remaining_count = 5'(left);
      want.failed_valid    = fail_latched;
      if (fail_latched && fail_idx < loaded) begin
        want.failed_slot  = 4'(fail_idx);
        want.failed_token = slot_tokens[fail_idx];
      end else begin
        want.failed_slot  = '0;
        want.failed_token = '0;
      end
      expected_status.push_back(want);
      return acc;
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void compare_status(status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        $error("status result with no request outstanding");
        errors++;
        return;
      end
      want = expected_status.pop_front();
      checked++;
      check_field("accepted", 64'(want.accepted), 64'(got.accepted));
      check_field("batch_state", 64'(want.batch_state), 64'(got.batch_state));
      check_field("remaining_count", 64'(want.remaining_count), 64'(got.remaining_count));
      check_field("failed_valid", 64'(want.failed_valid), 64'(got.failed_valid));
      check_field("failed_slot", 64'(want.failed_slot), 64'(got.failed_slot));
      check_field("failed_token", 64'(want.failed_token), 64'(got.failed_token));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  lcs_req_if req_bus ();
  lcs_rsp_if #(.CntW(5), .IdxW(4)) rsp_bus ();

  batch_tracker         tracker = new;
  logic [TokenBits-1:0] batch_tokens [$];
  bit                   jitter_on = 1'b1;
  bit                   long_hold_req = 1'b0;
  int                   sent_count = 0;
  int                   effective_count = 0;
  int                   settings_count = 0;

  load_completion_scoreboard uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : result_sink
    int      hold;
    status_t got;
    hold = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.accepted        = rsp_bus.accepted;
        got.batch_state     = rsp_bus.batch_state;
        got.remaining_count = rsp_bus.remaining_count;
        got.failed_valid    = rsp_bus.failed_valid;
        got.failed_slot     = rsp_bus.failed_slot;
        got.failed_token    = rsp_bus.failed_token;
        tracker.compare_status(got);
      end
      if (long_hold_req) begin
        hold          = LongHold;
        long_hold_req = 1'b0;
      end else if (hold == 0 && jitter_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 7);
      end
      if (hold > 0) begin
        hold--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  task automatic issue(input logic [ModeW-1:0] mode, input logic [TokenBits-1:0] token,
                       input logic [GenW-1:0] gen, input logic [OutcomeW-1:0] outcome);
    item_t it;
    it.mode               = mode;
    it.token              = token;
    it.request_generation = gen;
    it.outcome            = outcome;
    if (jitter_on && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    req_bus.valid              <= 1'b1;
    req_bus.mode               <= it.mode;
    req_bus.token              <= it.token;
    req_bus.request_generation <= it.request_generation;
    req_bus.outcome            <= it.outcome;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    sent_count++;
    if (tracker.absorb_request(it)) effective_count++;
  endtask

  task automatic pause_sender();
    req_bus.valid <= 1'b0;
    while (tracker.expected_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_generation(input logic [GenW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegBatchGen;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.gen = value;
    settings_count++;
  endtask

  function automatic logic [TokenBits-1:0] fresh_token();
    logic [TokenBits-1:0] t;
    bit                   taken;
    do begin
      t     = $urandom;
      taken = (t == '0);
      foreach (batch_tokens[i]) begin
        if (batch_tokens[i] == t) taken = 1'b1;
      end
    end while (taken);
    return t;
  endfunction

  task automatic issue_noise();
    logic [TokenBits-1:0] t;
    logic [GenW-1:0]      g;
    t = $urandom;
    if (batch_tokens.size() != 0 && $urandom_range(0, 1) == 0) begin
      t = batch_tokens[$urandom_range(0, batch_tokens.size() - 1)];
    end
    g = ($urandom_range(0, 1) == 0) ? tracker.gen : {$urandom, $urandom};
    issue(ModeW'($urandom_range(0, 7)), t, g, OutcomeW'($urandom_range(0, 3)));
  endtask

  task automatic run_batch();
    int              order [$];
    int              n;
    int              j;
    int              tmp;
    int              idx;
    logic [GenW-1:0] g;
    g = tracker.gen;
    batch_tokens.delete();
    issue(MODE_CLEAR, '0, '0, OUTCOME_READY);
    case ($urandom_range(0, 19)) inside
      0: n = 0;
      1, 2: n = MaxLoadsDef;
      default: n = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 5)
                                                  : $urandom_range(6, MaxLoadsDef);
    endcase
    for (int i = 0; i < n; i++) begin
      batch_tokens.push_back(fresh_token());
      issue(MODE_LOAD, batch_tokens[i], {$urandom, $urandom}, OutcomeW'($urandom_range(0, 3)));
    end
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: issue(MODE_LOAD, '0, g, OUTCOME_READY);
        1: issue(MODE_LOAD, (n > 0) ? batch_tokens[$urandom_range(0, n - 1)] : '0, g,
                 OUTCOME_READY);
        default: begin
          for (int i = n; i <= MaxLoadsDef; i++) begin
            batch_tokens.push_back(fresh_token());
            issue(MODE_LOAD, batch_tokens[i], g, OUTCOME_READY);
          end
        end
      endcase
    end
    if ($urandom_range(0, 19) == 0) issue_noise();
    issue(MODE_SEAL, $urandom, g, OUTCOME_READY);
    for (int i = 0; i < batch_tokens.size(); i++) order.push_back(i);
    for (int i = order.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[q]) begin
      idx = order[q];
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 4))
          0: issue(MODE_COMPLETE, batch_tokens[idx], g ^ (64'd1 << $urandom_range(0, 63)),
                   OUTCOME_READY);
          1: issue(MODE_COMPLETE, '0, g, OUTCOME_READY);
          2: issue(MODE_COMPLETE, batch_tokens[idx], g,
                   ($urandom_range(0, 1) != 0) ? OUTCOME_OTHER : OUTCOME_SPARE);
          3: issue(MODE_COMPLETE, fresh_token(), g, OUTCOME_READY);
          default: issue(MODE_COMPLETE, batch_tokens[order[0]], g, OUTCOME_READY);
        endcase
      end
      case ($urandom_range(0, 39)) inside
        0: begin
          issue(MODE_CANCEL, $urandom, g, OUTCOME_READY);
          break;
        end
        1: begin
          issue(MODE_TIMEOUT, $urandom, g, OUTCOME_READY);
          break;
        end
        2, 3: issue(MODE_COMPLETE, batch_tokens[idx], g, OUTCOME_FAILED);
        default: issue(MODE_COMPLETE, batch_tokens[idx], g, OUTCOME_READY);
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) issue_noise();
    end
  endtask

  initial begin : stimulus
    logic [GenW-1:0] g;
    int              target;
    bit              stalled;
    stalled                    = 1'b0;
    rst_ni                     <= 1'b0;
    psel                       <= 1'b0;
    penable                    <= 1'b0;
    pwrite                     <= 1'b0;
    paddr                      <= '0;
    pwdata                     <= '0;
    req_bus.valid              <= 1'b0;
    req_bus.mode               <= MODE_LOAD;
    req_bus.token              <= '0;
    req_bus.request_generation <= '0;
    req_bus.outcome            <= OUTCOME_READY;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(MODE_SEAL, '0, '0, OUTCOME_READY);
    issue(MODE_LOAD, 32'd1, '0, OUTCOME_READY);
    issue(MODE_CLEAR, '0, '0, OUTCOME_READY);
    pause_sender();
    write_generation('1);
    g = tracker.gen;
    issue(MODE_LOAD, 32'hFFFF_FFFF, g, OUTCOME_READY);
    issue(MODE_LOAD, 32'd1, g, OUTCOME_READY);
    issue(MODE_LOAD, 32'd1, g, OUTCOME_READY);
    issue(MODE_LOAD, 32'd5, g, OUTCOME_READY);
    issue(MODE_SEAL, '0, g, OUTCOME_READY);
    issue(MODE_CLEAR, '0, g, OUTCOME_READY);
    issue(MODE_SEAL, '0, g, OUTCOME_READY);
    issue(MODE_LOAD, 32'd9, g, OUTCOME_READY);
    issue(MODE_SEAL, '0, g, OUTCOME_READY);
    issue(MODE_CLEAR, '0, g, OUTCOME_READY);
    issue(MODE_LOAD, '0, g, OUTCOME_READY);
    issue(MODE_CLEAR, '0, g, OUTCOME_READY);
    issue(MODE_LOAD, 32'hFFFF_FFFF, g, OUTCOME_READY);
    issue(MODE_LOAD, 32'd1, g, OUTCOME_READY);
    issue(MODE_CANCEL, '0, g, OUTCOME_READY);
    issue(MODE_SEAL, '0, g, OUTCOME_READY);
    issue(MODE_COMPLETE, 32'hFFFF_FFFF, g ^ 64'd1, OUTCOME_READY);
    issue(MODE_COMPLETE, '0, g, OUTCOME_READY);
    issue(MODE_COMPLETE, 32'hFFFF_FFFF, g, OUTCOME_OTHER);
    issue(MODE_COMPLETE, 32'h0000_1234, g, OUTCOME_READY);
    issue(MODE_COMPLETE, 32'hFFFF_FFFF, g, OUTCOME_READY);
    issue(MODE_COMPLETE, 32'hFFFF_FFFF, g, OUTCOME_READY);
    issue(MODE_COMPLETE, 32'd1, g, OUTCOME_FAILED);
    issue(MODE_TIMEOUT, '0, g, OUTCOME_READY);
    issue(MODE_RSVD_LO, 32'd1, g, OUTCOME_READY);
    issue(MODE_RSVD_HI, 32'd1, g, OUTCOME_SPARE);
    issue(MODE_CLEAR, '0, g, OUTCOME_READY);

    for (int k = 0; k < Phases; k++) begin
      case (k)
        0: g = 64'd1;
        1: g = '1;
        3: g = '0;
        5: g = 64'h8000_0000_0000_0000;
        default: g = {$urandom, $urandom};
      endcase
      pause_sender();
      write_generation(g);
      target = sent_count + PhaseWork;
      while (sent_count < target) begin
        jitter_on = (k != Phases - 1) && ($urandom_range(0, 3) != 0);
        if (k == 2 && !stalled) begin
          long_hold_req = 1'b1;
          stalled       = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(4, 12)) issue_noise();
        end else begin
          run_batch();
        end
      end
    end

    pause_sender();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d requests, %0d of them taking effect, over %0d generation settings.",
             sent_count, effective_count, settings_count);
    $display("Compared %0d status results with %0d mismatches.", tracker.checked,
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
